### sv/sbsh_pkg.sv
// Shared types and constants of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package sbsh_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned ROUNDS      = 64;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    // Last fill level that still leaves room for the length in the same block.
    localparam logic [5:0] LONG_FILL = 6'd55;
    localparam logic [5:0] FULL_FILL = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       write_byte;
        logic       init_work;
        logic       pad_block;
        logic       len_block;
        logic       round_en;
        logic [5:0] round_idx;
        logic       update;
        logic       restart;
        logic [2:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_status;

endpackage

`default_nettype wire

### sv/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// A byte that does not complete a block is written into the window; a byte that fills the
// 64-byte block starts 64 rounds of one round unit, then one chaining update.
// End of message: padding, then rounds and update per final block (one or two), then 8 beats.
// Throughput: one byte per cycle within a block while idle; the block-completing byte holds
// the input until its rounds and chaining update are done.
// Reset (synchronous, active low) loads the initial hash values and clears the counts.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tuser,   // [0] byte_present
    input  wire         i_s_axis_tlast,   // end_of_message
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zeros
    output logic        o_m_axis_tlast    // last_word
);
    import sbsh_pkg::*;

    t_dp_cmd     cmd;
    t_dp_status  status;
    logic [31:0] digest_word;

    // Sequencer: accepts beats only while idle, runs padding and the round loop,
    // then presents the eight digest words from the hash registers.
    sbsh_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_s_axis_tvalid),
        .i_byte_present   (i_s_axis_tuser),
        .i_end_of_message (i_s_axis_tlast),
        .o_in_ready       (o_s_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_out_last       (o_m_axis_tlast),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    // Datapath: block window doubling as the message schedule, one round per cycle.
    sbsh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_s_axis_tdata),
        .o_status      (status),
        .o_digest_word (digest_word)
    );

    // Word index is the sequencer's output counter; pad the beat to whole bytes.
    assign o_m_axis_tdata = {5'b00000, cmd.out_idx, digest_word};

    // Input and output never open together: the block holds one message step at a time.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input and output handshakes open together");

    // The final digest beat carries word index seven.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata[34:32] == LAST_WORD))
        else $error("last digest beat with wrong index");

    // After the final digest beat the block is idle again with an empty buffer.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast && i_m_axis_tready)
        |=> (o_s_axis_tready && (status.fill == 6'd0)))
        else $error("no clean restart after digest");

    // Rounds never overlap a byte write into the window.
    a_round_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.round_en && (cmd.write_byte || cmd.pad_block)))
        else $error("round step collides with window write");

endmodule

`default_nettype wire

### sv/sbsh_datapath.sv
// Datapath of the SHA-256 hasher: block window, schedule, round logic, hash words.
`timescale 1ns / 1ps
`default_nettype none

module sbsh_datapath (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire sbsh_pkg::t_dp_cmd i_cmd,
    input  wire [7:0]             i_data_byte,
    output sbsh_pkg::t_dp_status  o_status,
    output logic [31:0]           o_digest_word
);
    import sbsh_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] r_w    [BLOCK_WORDS];
    logic [31:0] n_w    [BLOCK_WORDS];
    logic [31:0] r_hash [HASH_WORDS];
    logic [31:0] n_hash [HASH_WORDS];
    logic [31:0] r_work [HASH_WORDS];
    logic [31:0] n_work [HASH_WORDS];
    logic [5:0]  r_fill, n_fill;
    logic [28:0] r_total, n_total;

    logic [31:0] bit_len;
    logic [31:0] sched_new;
    logic [31:0] t1, t2;

    assign bit_len = {r_total, 3'b000};

    assign sched_new = (rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10))
                     + r_w[9]
                     + (rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3))
                     + r_w[0];

    assign t1 = r_work[7]
              + (rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25))
              + ((r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]))
              + ROUND_K[i_cmd.round_idx] + r_w[0];
    assign t2 = (rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22))
              + ((r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                 ^ (r_work[1] & r_work[2]));

    // Block window: byte fill, padding, and the sliding schedule during rounds.
    always_comb begin
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            n_w[i] = r_w[i];
        end
        if (i_cmd.round_en) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[BLOCK_WORDS - 1] = sched_new;
        end else if (i_cmd.pad_block) begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                for (int j = 0; j < 4; j++) begin
                    pos = 6'(4 * i + j);
                    if (pos == r_fill) begin
                        n_w[i][8 * (3 - j) +: 8] = PAD_BYTE;
                    end else if (pos > r_fill) begin
                        n_w[i][8 * (3 - j) +: 8] = 8'h00;
                    end
                end
            end
            if (r_fill <= LONG_FILL) begin
                n_w[BLOCK_WORDS - 1] = bit_len;
            end
        end else if (i_cmd.len_block) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                n_w[i] = 32'h0;
            end
            n_w[BLOCK_WORDS - 1] = bit_len;
        end else if (i_cmd.write_byte) begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                for (int j = 0; j < 4; j++) begin
                    pos = 6'(4 * i + j);
                    if (pos == r_fill) begin
                        n_w[i][8 * (3 - j) +: 8] = i_data_byte;
                    end
                end
            end
        end
    end

    // Working variables and chaining value.
    always_comb begin
        for (int i = 0; i < HASH_WORDS; i++) begin
            n_hash[i] = r_hash[i];
            n_work[i] = r_work[i];
        end
        if (i_cmd.restart) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                n_hash[i] = INIT_HASH[i];
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                n_hash[i] = r_hash[i] + r_work[i];
                n_work[i] = r_hash[i] + r_work[i];
            end
        end
        if (i_cmd.init_work) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                n_work[i] = r_hash[i];
            end
        end else if (i_cmd.round_en) begin
            n_work[0] = t1 + t2;
            n_work[1] = r_work[0];
            n_work[2] = r_work[1];
            n_work[3] = r_work[2];
            n_work[4] = r_work[3] + t1;
            n_work[5] = r_work[4];
            n_work[6] = r_work[5];
            n_work[7] = r_work[6];
        end
    end

    always_comb begin
        n_fill  = r_fill;
        n_total = r_total;
        if (i_cmd.restart) begin
            n_fill  = 6'd0;
            n_total = 29'd0;
        end else if (i_cmd.write_byte) begin
            n_fill  = r_fill + 6'd1;
            n_total = r_total + 29'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= 6'd0;
            r_total <= 29'd0;
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_hash[i] <= INIT_HASH[i];
            end
        end else begin
            r_fill  <= n_fill;
            r_total <= n_total;
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_hash[i] <= n_hash[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            r_w[i] <= n_w[i];
        end
        for (int i = 0; i < HASH_WORDS; i++) begin
            r_work[i] <= n_work[i];
        end
    end

    assign o_status.fill = r_fill;
    assign o_digest_word = r_hash[i_cmd.out_idx];

endmodule

`default_nettype wire

### sv/sbsh_ctrl.sv
// Sequencer of the SHA-256 hasher: byte intake, padding, rounds and digest output.
`timescale 1ns / 1ps
`default_nettype none

module sbsh_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire                      i_byte_present,
    input  wire                      i_end_of_message,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic                     o_out_last,
    input  wire sbsh_pkg::t_dp_status i_status,
    output sbsh_pkg::t_dp_cmd        o_cmd
);
    import sbsh_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [2:0] r_widx, n_widx;
    logic       r_end_pend, n_end_pend;
    logic       r_second, n_second;
    logic       r_final, n_final;

    logic in_acc;
    logic block_full;

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign block_full = i_byte_present && (i_status.fill == FULL_FILL);

    // Next state and sequencing flags.
    always_comb begin
        n_state    = r_state;
        n_round    = 6'd0;
        n_widx     = r_widx;
        n_end_pend = r_end_pend;
        n_second   = r_second;
        n_final    = r_final;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (block_full) begin
                        n_state    = ST_ROUND;
                        n_end_pend = i_end_of_message;
                        n_second   = 1'b0;
                        n_final    = 1'b0;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_state    = ST_ROUND;
                n_end_pend = 1'b0;
                n_second   = (i_status.fill > LONG_FILL);
                n_final    = (i_status.fill <= LONG_FILL);
            end
            ST_ROUND: begin
                n_round = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (r_second) begin
                    n_state  = ST_ROUND;
                    n_second = 1'b0;
                    n_final  = 1'b1;
                end else if (r_final) begin
                    n_state = ST_OUT;
                    n_widx  = 3'd0;
                    n_final = 1'b0;
                end else if (r_end_pend) begin
                    n_state    = ST_PAD;
                    n_end_pend = 1'b0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == LAST_WORD) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands and handshake outputs.
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.write_byte = in_acc && i_byte_present;
                o_cmd.init_work  = in_acc && block_full;
            end
            ST_PAD: begin
                o_cmd.pad_block = 1'b1;
                o_cmd.init_work = 1'b1;
            end
            ST_ROUND: begin
                o_cmd.round_en  = 1'b1;
                o_cmd.round_idx = r_round;
            end
            ST_UPDATE: begin
                o_cmd.update    = 1'b1;
                o_cmd.len_block = r_second;
            end
            ST_OUT: begin
                o_out_valid   = 1'b1;
                o_out_last    = (r_widx == LAST_WORD);
                o_cmd.out_idx = r_widx;
                o_cmd.restart = i_out_ready && (r_widx == LAST_WORD);
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_round    <= 6'd0;
            r_widx     <= 3'd0;
            r_end_pend <= 1'b0;
            r_second   <= 1'b0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_widx     <= n_widx;
            r_end_pend <= n_end_pend;
            r_second   <= n_second;
            r_final    <= n_final;
        end
    end

endmodule

`default_nettype wire

### test/sha256_byte_stream_hasher_tb.sv
// Self-checking testbench for the SHA-256 byte stream hasher against a local digest model.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb;

    // SHA-256 round constants and initial hash values, kept local so that the
    // predictor does not share any table with the design.
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] MSG_PAD      = 8'h80;
    // Highest fill level that still leaves room for the length word.
    localparam logic [5:0] TAIL_ROOM    = 6'd55;
    localparam logic [2:0] FINAL_WORD   = 3'd7;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         HOLD_AFTER   = 16;
    localparam int         TARGET_ITEMS = 210;
    localparam int         DRAIN_CYCLES = 160;

    // One digest word as it should leave the block.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    // Digest predictor and store of expected digest words.
    class digest_tracker;
        logic [31:0]  hash_state [8];
        logic [7:0]   block_buf [64];
        logic [5:0]   fill;
        logic [28:0]  byte_total;
        t_digest_beat expected_q [$];
        int unsigned  mismatches;
        int unsigned  words_checked;
        int unsigned  messages;
        int unsigned  long_tails;
        int unsigned  block_ends;
        int unsigned  ignored;
        int unsigned  bytes_taken;

        function new();
            restart();
        endfunction

        function void restart();
            for (int k = 0; k < 8; k++) hash_state[k] = SHA_IV[k];
            fill       = '0;
            byte_total = '0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            for (int j = 0; j < 16; j++)
                w[j] = {block_buf[4*j], block_buf[4*j+1], block_buf[4*j+2], block_buf[4*j+3]};
            for (int j = 16; j < 64; j++) begin
                s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
                s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
                w[j] = s1 + w[j-7] + s0 + w[j-16];
            end
            a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
            e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
            for (int j = 0; j < 64; j++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                     + SHA_K[j] + w[j];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
            hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
        endfunction

        // Note one accepted input beat; queue the digest when it ends a message.
        function void absorb_item(logic [7:0] data, logic present, logic last);
            logic [31:0]  bit_len;
            t_digest_beat beat;
            if (!present && !last) begin
                ignored++;
                return;
            end
            if (present) begin
                block_buf[fill] = data;
                byte_total++;
                bytes_taken++;
                fill++;
                if (fill == 0) begin
                    compress();
                    if (last) block_ends++;
                end
            end
            if (!last) return;
            block_buf[fill] = MSG_PAD;
            for (int j = int'(fill) + 1; j < 64; j++) block_buf[j] = '0;
            if (fill > TAIL_ROOM) begin
                compress();
                for (int j = 0; j < 64; j++) block_buf[j] = '0;
                long_tails++;
            end
            bit_len = {byte_total, 3'b000};
            block_buf[60] = bit_len[31:24];
            block_buf[61] = bit_len[23:16];
            block_buf[62] = bit_len[15:8];
            block_buf[63] = bit_len[7:0];
            compress();
            for (int k = 0; k < 8; k++) begin
                beat.word = hash_state[k];
                beat.idx  = 3'(k);
                beat.last = (3'(k) == FINAL_WORD);
                expected_q = {expected_q, beat};
            end
            messages++;
            restart();
        endfunction

        // Compare one accepted output beat with the oldest expected word.
        function void check_word(logic [39:0] tdata, logic tlast);
            t_digest_beat exp_beat;
            if (expected_q.size() == 0) begin
                $error("digest beat with nothing expected: tdata=%h tlast=%b", tdata, tlast);
                mismatches++;
                return;
            end
            exp_beat = expected_q.pop_front();
            words_checked++;
            if (tdata[31:0] !== exp_beat.word) begin
                $error("digest_word: expected %h, got %h", exp_beat.word, tdata[31:0]);
                mismatches++;
            end
            if (tdata[34:32] !== exp_beat.idx) begin
                $error("word_index: expected %0d, got %0d", exp_beat.idx, tdata[34:32]);
                mismatches++;
            end
            if (tlast !== exp_beat.last) begin
                $error("last_word: expected %b, got %b", exp_beat.last, tlast);
                mismatches++;
            end
            if (tdata[39:35] !== 5'd0) begin
                $error("tdata padding: expected %h, got %h", 5'd0, tdata[39:35]);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;    // [7:0] data_byte
    logic        i_s_axis_tuser;    // [0] byte_present
    logic        i_s_axis_tlast;    // end_of_message
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;    // [31:0] digest_word, [34:32] word_index, [39:35] zeros
    logic        o_m_axis_tlast;    // last_word

    digest_tracker sb;
    int unsigned   items_sent;
    bit            sender_idles;

    sha256_byte_stream_hasher i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle length between beats: mostly none, some short, a few long.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(12, 48);
    endfunction

    // Offer one beat and hold it until the block takes it, then maybe idle for a while.
    // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
    task automatic offer_beat(input logic [7:0] data, input logic present, input logic last);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= present;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.absorb_item(data, present, last);
        items_sent++;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send one message of random bytes. The end flag rides either on the last byte
    // or on a separate beat without a byte; stray ignored beats are mixed in.
    task automatic send_message(input int len, input bit end_on_byte);
        sender_idles = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 6)
                offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
            offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Sender: reset, directed messages, then random messages, then drain.
    initial begin
        int unsigned r;
        int          len;
        int          room;
        sb = new();
        items_sent      = 0;
        sender_idles    = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty message straight after reset: end flag with no byte.
        offer_beat(8'h00, 1'b0, 1'b1);
        // Ignored beat, then a lone zero byte carrying the end flag.
        offer_beat(8'hA5, 1'b0, 1'b0);
        offer_beat(8'h00, 1'b1, 1'b1);
        // Lone all-ones byte with the end flag.
        offer_beat(8'hFF, 1'b1, 1'b1);
        // Three bytes, end on a separate beat with all-ones data.
        offer_beat(8'h61, 1'b1, 1'b0);
        offer_beat(8'h62, 1'b1, 1'b0);
        offer_beat(8'h63, 1'b1, 1'b0);
        offer_beat(8'hFF, 1'b0, 1'b1);
        // Ignored all-ones beat, then two extreme bytes with the end on the second.
        offer_beat(8'hFF, 1'b0, 1'b0);
        offer_beat(8'hFF, 1'b1, 1'b0);
        offer_beat(8'h00, 1'b1, 1'b1);
        // Two empty messages back to back.
        offer_beat(8'h5A, 1'b0, 1'b1);
        offer_beat(8'hC3, 1'b0, 1'b1);

        // Block boundaries first: a tail too long for the length word, then a
        // message whose last byte completes a block.
        send_message(56, 1'b0);
        send_message(64, 1'b1);
        while (items_sent < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            len = (r < 18) ? $urandom_range(54, 65) : $urandom_range(0, 12);
            // Trim the last message so the run stays close to the beat budget.
            room = TARGET_ITEMS - int'(items_sent);
            if (len > room) len = room;
            send_message(len, 1'($urandom_range(0, 1)));
        end
        i_s_axis_tvalid <= 1'b0;

        // Wait for every digest word, then watch a while longer for strays.
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d messages (%0d long tails, %0d ending on a block edge)",
                 sb.messages, sb.long_tails, sb.block_ends);
        $display("%0d bytes, %0d skipped beats, %0d digest words checked, %0d mismatches",
                 sb.bytes_taken, sb.ignored, sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: random ready with gaps, plus one long hold-off once a couple of
    // digests have gone through, so that the block backs up and stalls its input.
    initial begin
        bit hold_done;
        int run;
        int gap;
        hold_done = 1'b0;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!hold_done && sb.words_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge i_clk);
            gap = ($urandom_range(0, 9) < 4) ? 0 : pick_gap();
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Check every accepted output beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word(o_m_axis_tdata, o_m_axis_tlast);
    end

    // Hard stop, well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
